FILE: rtl/voxel_boundary_face_count_macros.svh
// Assertion macros shared by the voxel boundary face counter checker.
`ifndef VOXEL_BOUNDARY_FACE_COUNT_MACROS_SVH
`define VOXEL_BOUNDARY_FACE_COUNT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define VBFC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vbfc assertion failed");

// Next-cycle implication, masked while reset is high.
`define VBFC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vbfc assertion failed");

// Next-cycle implication that also holds across reset.
`define VBFC_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vbfc assertion failed");

`endif

FILE: rtl/vbfc_pkg.sv
// Shared types and constants of the voxel boundary face counter.
package vbfc_pkg;

   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE_ZERO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_BOUNDARY = 3'd4;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = 2;
   localparam int FIFO_CW = 3;

   localparam int NB_COUNT = 6;
   localparam int NB_OWN = 0;
   localparam int NB_MINUS_PLANE = 1;
   localparam int NB_MINUS_ROW = 2;
   localparam int NB_MINUS_ONE = 3;
   localparam int NB_PLUS_ONE = 4;
   localparam int NB_PLUS_ROW = 5;

   typedef struct packed {
      opcode_type opcode;
      logic signed [31:0] feature_id;
   } req_type;

   typedef struct packed {
      logic [23:0] cell_index;
      logic [2:0] boundary_count;
      logic last_cell;
   } rsp_type;

   // Report job handed from the front end to the back end.
   typedef struct packed {
      logic valid;
      logic [23:0] cell_index;
      logic last_cell;
      logic [2:0] on_face;
      logic [5:0] nb_en;
      logic signed [31:0] upper_id;
      logic ignore_zero;
      logic volume_boundary;
   } job_type;

   typedef struct packed {
      logic [FIFO_CW-1:0] fill;
   } back_status_type;

endpackage

FILE: rtl/vbfc_window_ram.sv
// Window store copy: one write port and two registered read ports.
module vbfc_window_ram #(
   parameter int DEPTH = 32768,
   parameter int AW = 15,
   parameter int WIDTH = 32
) (
   input  logic clock,
   input  logic we,
   input  logic [AW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0] raddr_a,
   input  logic [AW-1:0] raddr_b,
   output logic [WIDTH-1:0] rdata_a_ff,
   output logic [WIDTH-1:0] rdata_b_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Reads return the contents from before a write at the same edge.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

endmodule

FILE: rtl/vbfc_front.sv
// Front end: configuration, voxel and report bookkeeping, window addressing.
module vbfc_front #(
   parameter int MAX_X = 128,
   parameter int MAX_Y = 128,
   parameter int MAX_Z = 1024,
   parameter int ID_WIDTH = 32,
   parameter int AW = 15,
   parameter int DEPTH = 32768
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [vbfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vbfc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  vbfc_pkg::req_type req_data,
   input  vbfc_pkg::back_status_type back_status,
   output logic ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [ID_WIDTH-1:0] ram_wdata,
   output logic [vbfc_pkg::NB_COUNT-1:0][AW-1:0] ram_raddr,
   output vbfc_pkg::job_type job_ff
);
   import vbfc_pkg::*;

   localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int DXW = $clog2(MAX_X + 1);
   localparam int DYW = $clog2(MAX_Y + 1);
   localparam int DZW = $clog2(MAX_Z + 1);
   localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [DXW-1:0] dx_ff, dx_in;
   logic [DYW-1:0] dy_ff, dy_in;
   logic [DZW-1:0] dz_ff, dz_in;
   logic ign_ff, ign_in;
   logic incl_ff, incl_in;
   logic [AW-1:0] plane_ff;

   logic [XW-1:0] ax_ff, ax_in, cx_ff, cx_in;
   logic [YW-1:0] ay_ff, ay_in, cy_ff, cy_in;
   logic [ZW-1:0] az_ff, az_in, cz_ff, cz_in;
   logic acc_full_ff, acc_full_in;
   logic emit_done_ff, emit_done_in;
   logic [AW-1:0] wp_ff, wp_in, ep_ff, ep_in;
   logic [23:0] e_ff, e_in;
   job_type job_in;

   logic size_write;
   logic accept;
   logic is_data;
   logic restart;
   logic do_write;
   logic do_rep;
   logic [AW-1:0] wp_base;
   logic ax_last, ay_last, az_last;
   logic cx_last, cy_last, cz_last;
   logic [AW-1:0] sx_off;

   function automatic logic [AW-1:0] slot_sub(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] t;
      t = {1'b0, base} - {1'b0, off};
      if (t[AW]) begin
         t = t + DEPTH_V;
      end
      return t[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
      logic [AW:0] t;
      t = {1'b0, base} + {1'b0, off};
      if (t >= DEPTH_V) begin
         t = t - DEPTH_V;
      end
      return t[AW-1:0];
   endfunction

   // Clamped sizes and flags taken from the configuration port.
   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      dz_in = dz_ff;
      ign_in = ign_ff;
      incl_in = incl_ff;
      size_write = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: begin
               size_write = 1'b1;
               if (csr_wdata[7:0] == 8'd0) dx_in = DXW'(1);
               else if (32'(csr_wdata[7:0]) > MAX_X) dx_in = DXW'(MAX_X);
               else dx_in = DXW'(csr_wdata[7:0]);
            end
            CSR_SIZE_Y: begin
               size_write = 1'b1;
               if (csr_wdata[7:0] == 8'd0) dy_in = DYW'(1);
               else if (32'(csr_wdata[7:0]) > MAX_Y) dy_in = DYW'(MAX_Y);
               else dy_in = DYW'(csr_wdata[7:0]);
            end
            CSR_SIZE_Z: begin
               size_write = 1'b1;
               if (csr_wdata == 11'd0) dz_in = DZW'(1);
               else if (32'(csr_wdata) > MAX_Z) dz_in = DZW'(MAX_Z);
               else dz_in = DZW'(csr_wdata);
            end
            CSR_IGNORE_ZERO: ign_in = csr_wdata[0];
            CSR_VOLUME_BOUNDARY: incl_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Room is reserved in the result queue for the job already in flight.
   assign req_ready = (32'(back_status.fill) + 32'(job_ff.valid)) < FIFO_DEPTH;
   assign accept = req_valid && req_ready;
   assign is_data = (req_data.opcode == OP_DATA);

   assign ax_last = (DXW'(ax_ff) == dx_ff - 1'b1);
   assign ay_last = (DYW'(ay_ff) == dy_ff - 1'b1);
   assign az_last = (DZW'(az_ff) == dz_ff - 1'b1);
   assign cx_last = (DXW'(cx_ff) == dx_ff - 1'b1);
   assign cy_last = (DYW'(cy_ff) == dy_ff - 1'b1);
   assign cz_last = (DZW'(cz_ff) == dz_ff - 1'b1);

   // Classify the item: new voxel, restart of a finished grid, or a flush.
   assign restart = is_data && acc_full_ff && emit_done_ff;
   assign do_write = accept && is_data && !(acc_full_ff && !emit_done_ff);
   assign do_rep = accept && ((is_data && !acc_full_ff && (az_ff != '0)) ||
                              (!is_data && acc_full_ff && !emit_done_ff));
   assign wp_base = restart ? '0 : wp_ff;
   assign sx_off = AW'(dx_ff);

   // Counter and coordinate updates.
   always_comb begin
      ax_in = ax_ff;
      ay_in = ay_ff;
      az_in = az_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      acc_full_in = acc_full_ff;
      emit_done_in = emit_done_ff;
      wp_in = wp_ff;
      ep_in = ep_ff;
      e_in = e_ff;
      if (size_write) begin
         ax_in = '0;
         ay_in = '0;
         az_in = '0;
         cx_in = '0;
         cy_in = '0;
         cz_in = '0;
         acc_full_in = 1'b0;
         emit_done_in = 1'b0;
         wp_in = '0;
         ep_in = '0;
         e_in = '0;
      end else begin
         if (accept && restart) begin
            acc_full_in = 1'b0;
            emit_done_in = 1'b0;
            cx_in = '0;
            cy_in = '0;
            cz_in = '0;
            ep_in = '0;
            e_in = '0;
         end
         if (do_write) begin
            wp_in = (wp_base == LAST_SLOT) ? '0 : wp_base + 1'b1;
            ax_in = ax_last ? '0 : ax_ff + 1'b1;
            if (ax_last) begin
               ay_in = ay_last ? '0 : ay_ff + 1'b1;
               if (ay_last) begin
                  az_in = az_last ? '0 : az_ff + 1'b1;
                  if (az_last) acc_full_in = 1'b1;
               end
            end
         end
         if (do_rep) begin
            ep_in = (ep_ff == LAST_SLOT) ? '0 : ep_ff + 1'b1;
            e_in = e_ff + 1'b1;
            cx_in = cx_last ? '0 : cx_ff + 1'b1;
            if (cx_last) begin
               cy_in = cy_last ? '0 : cy_ff + 1'b1;
               if (cy_last) begin
                  cz_in = cz_ff + 1'b1;
                  if (cz_last) emit_done_in = 1'b1;
               end
            end
         end
      end
   end

   // Window write of the new voxel and neighbor reads of the reported one.
   assign ram_we = do_write;
   assign ram_waddr = wp_base;
   assign ram_wdata = req_data.feature_id[ID_WIDTH-1:0];
   assign ram_raddr[NB_OWN] = ep_ff;
   assign ram_raddr[NB_MINUS_PLANE] = slot_sub(ep_ff, plane_ff);
   assign ram_raddr[NB_MINUS_ROW] = slot_sub(ep_ff, sx_off);
   assign ram_raddr[NB_MINUS_ONE] = slot_sub(ep_ff, AW'(1));
   assign ram_raddr[NB_PLUS_ONE] = slot_add(ep_ff, AW'(1));
   assign ram_raddr[NB_PLUS_ROW] = slot_add(ep_ff, sx_off);

   // Job description for the back end.
   always_comb begin
      job_in.valid = do_rep;
      job_in.cell_index = e_ff;
      job_in.last_cell = cx_last && cy_last && cz_last;
      job_in.on_face[0] = (dx_ff > DXW'(2)) && ((cx_ff == '0) || cx_last);
      job_in.on_face[1] = (dy_ff > DYW'(2)) && ((cy_ff == '0) || cy_last);
      job_in.on_face[2] = (dz_ff > DZW'(2)) && ((cz_ff == '0) || cz_last);
      job_in.nb_en[0] = (cz_ff != '0);
      job_in.nb_en[1] = (cy_ff != '0);
      job_in.nb_en[2] = (cx_ff != '0);
      job_in.nb_en[3] = !cx_last;
      job_in.nb_en[4] = !cy_last;
      job_in.nb_en[5] = !cz_last && is_data;
      job_in.upper_id = 32'($signed(req_data.feature_id[ID_WIDTH-1:0]));
      job_in.ignore_zero = ign_ff;
      job_in.volume_boundary = incl_ff;
   end

   // Configuration, control and job registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dx_ff <= DXW'(1);
         dy_ff <= DYW'(1);
         dz_ff <= DZW'(1);
         ign_ff <= 1'b1;
         incl_ff <= 1'b0;
         ax_ff <= '0;
         ay_ff <= '0;
         az_ff <= '0;
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         acc_full_ff <= 1'b0;
         emit_done_ff <= 1'b0;
         wp_ff <= '0;
         ep_ff <= '0;
         e_ff <= '0;
         job_ff <= '0;
      end else begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         ign_ff <= ign_in;
         incl_ff <= incl_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         acc_full_ff <= acc_full_in;
         emit_done_ff <= emit_done_in;
         wp_ff <= wp_in;
         ep_ff <= ep_in;
         e_ff <= e_in;
         job_ff <= job_in;
      end
   end

   // The plane size needs no reset.
   always_ff @(posedge clock) begin
      plane_ff <= AW'(AW'(dx_ff) * AW'(dy_ff));
   end

endmodule

FILE: rtl/vbfc_back.sv
// Back end: face count of a reported voxel and the result queue.
module vbfc_back #(
   parameter int ID_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  vbfc_pkg::job_type job,
   input  logic [vbfc_pkg::NB_COUNT-1:0][ID_WIDTH-1:0] nb_raw,
   output vbfc_pkg::back_status_type back_status,
   output logic rsp_valid,
   input  logic rsp_ready,
   output vbfc_pkg::rsp_type rsp_data
);
   import vbfc_pkg::*;

   logic signed [31:0] own;
   logic signed [5:0][31:0] nb;
   logic [5:0] nb_hit;
   logic [3:0] sum;
   rsp_type result;

   rsp_type fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [FIFO_CW-1:0] fill_ff, fill_in;
   logic push, pop;

   // Neighbor ids in the order of the enable bits of the job.
   always_comb begin
      own = 32'($signed(nb_raw[NB_OWN]));
      nb[0] = 32'($signed(nb_raw[NB_MINUS_PLANE]));
      nb[1] = 32'($signed(nb_raw[NB_MINUS_ROW]));
      nb[2] = 32'($signed(nb_raw[NB_MINUS_ONE]));
      nb[3] = 32'($signed(nb_raw[NB_PLUS_ONE]));
      nb[4] = 32'($signed(nb_raw[NB_PLUS_ROW]));
      nb[5] = job.upper_id;
   end

   // A neighbor counts when it is enabled, non-negative, differs and passes the feature-zero policy.
   always_comb begin
      for (int i = 0; i < NB_COUNT; i++) begin
         nb_hit[i] = job.nb_en[i] && (nb[i] != own) && !nb[i][31] &&
                     !(job.ignore_zero && (nb[i] == 32'sd0));
      end
   end

   always_comb begin
      sum = '0;
      if (!own[31]) begin
         for (int i = 0; i < NB_COUNT; i++) begin
            sum = sum + 4'(nb_hit[i]);
         end
         if (job.volume_boundary && (own != 32'sd0)) begin
            for (int i = 0; i < 3; i++) begin
               sum = sum + 4'(job.on_face[i]);
            end
         end
      end
      result.cell_index = job.cell_index;
      result.boundary_count = sum[2:0];
      result.last_cell = job.last_cell;
   end

   // Result queue; the front end never issues a job without a free entry.
   assign push = job.valid;
   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = (fill_ff != '0);
   assign rsp_data = fifo_mem[rd_ptr_ff];
   assign back_status.fill = fill_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= result;
      end
   end

endmodule

FILE: rtl/voxel_boundary_face_count.sv
// Top level of the streaming six-connected voxel boundary face counter.
// Usage:
//   req channel (valid/ready): opcode 0 carries the next voxel id in raster
//   order, x fastest; opcode 1 asks for one pending result once the whole
//   grid has arrived. rsp channel (valid/ready): cell index, face count, and
//   a flag on the final voxel of the grid.
//   csr port: write enable, register index and data; sizes, feature-zero
//   policy and volume boundary mode. Write only while the block is idle.
// Timing:
//   A voxel's result is produced by the item that supplies its +z neighbor,
//   so results trail the input by one plane; the last plane is flushed by
//   drain items. One item is taken per cycle while req_ready is high. A
//   result reaches rsp through the registered window reads and the job
//   register, then the count is written into the result queue.
//   The window store has three copies with two read ports each so that the
//   voxel's own id and five neighbor ids are read in the same cycle.
// Reset and stall:
//   Reset restores the register defaults and empties the queue; the window
//   store needs no clearing. When rsp stalls, the four-entry queue fills and
//   req_ready drops until it drains.
module voxel_boundary_face_count #(
   parameter int MAX_X = 128,
   parameter int MAX_Y = 128,
   parameter int MAX_Z = 1024,
   parameter int ID_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [vbfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vbfc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  vbfc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output vbfc_pkg::rsp_type rsp_data
);
   import vbfc_pkg::*;

   localparam int DEPTH = 2 * MAX_X * MAX_Y;
   localparam int AW = $clog2(DEPTH);

   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic [ID_WIDTH-1:0] ram_wdata;
   logic [NB_COUNT-1:0][AW-1:0] ram_raddr;
   logic [NB_COUNT-1:0][ID_WIDTH-1:0] ram_rdata;
   job_type job;
   back_status_type back_status;

   vbfc_front #(
      .MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z), .ID_WIDTH(ID_WIDTH),
      .AW(AW), .DEPTH(DEPTH)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .back_status(back_status),
      .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr), .job_ff(job)
   );

   // Three identical window copies, each serving two of the six reads.
   for (genvar g = 0; g < NB_COUNT / 2; g++) begin : g_win
      vbfc_window_ram #(.DEPTH(DEPTH), .AW(AW), .WIDTH(ID_WIDTH)) u_ram (
         .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
         .raddr_a(ram_raddr[2*g]), .raddr_b(ram_raddr[2*g+1]),
         .rdata_a_ff(ram_rdata[2*g]), .rdata_b_ff(ram_rdata[2*g+1])
      );
   end

   vbfc_back #(.ID_WIDTH(ID_WIDTH)) u_back (
      .clock(clock), .reset(reset), .job(job), .nb_raw(ram_rdata),
      .back_status(back_status),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

FILE: rtl/vbfc_checker.sv
// Port-level checker of the voxel boundary face counter and its binding.
`include "voxel_boundary_face_count_macros.svh"

module vbfc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input vbfc_pkg::rsp_type rsp_data
);
   import vbfc_pkg::*;

   // A stalled result keeps its payload.
   `VBFC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A voxel never has more than six faces.
   `VBFC_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_data.boundary_count <= 3'd6)

   // The result queue is empty after reset.
   `VBFC_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind voxel_boundary_face_count vbfc_checker u_vbfc_checker (.*);
